FILE: src/mpt_pkg.sv
// memory patch table package: beat structs, table entry, cell control and codes
// used by mpt_cell and memory_patch_table; no dependencies
`timescale 1ns / 1ps

package mpt_pkg;

   localparam int CAPACITY_DEFAULT = 64;

   localparam logic [2:0] OP_APPEND = 3'd0;
   localparam logic [2:0] OP_DELETE = 3'd1;
   localparam logic [2:0] OP_READ   = 3'd2;
   localparam logic [2:0] OP_SET_EN = 3'd3;
   localparam logic [2:0] OP_APPLY  = 3'd4;
   localparam logic [2:0] OP_CLEAR  = 3'd5;

   localparam logic [2:0] CMD_HOLD   = 3'd0;
   localparam logic [2:0] CMD_ROTATE = 3'd1;
   localparam logic [2:0] CMD_SHIFT  = 3'd2;
   localparam logic [2:0] CMD_WRITE  = 3'd3;
   localparam logic [2:0] CMD_SET_EN = 3'd4;

   typedef struct packed {
      logic [2:0]  opcode;
      logic [7:0]  entry_index;
      logic [15:0] patch_addr;
      logic [7:0]  patch_value;
      logic        enable_in;
   } req_type;

   typedef struct packed {
      logic        ok;
      logic [5:0]  slot;
      logic [15:0] addr_out;
      logic [7:0]  value_out;
      logic        enable_out;
      logic        write_strobe;
      logic        last;
   } rsp_type;

   typedef struct packed {
      logic [15:0] addr;
      logic [7:0]  value;
      logic        en;
   } entry_type;

   typedef struct packed {
      logic [2:0] cmd;
      logic [7:0] sel;
      entry_type  wr_entry;
   } cell_ctl_type;

endpackage

FILE: src/mpt_cell.sv
// one table cell: holds a single patch entry, takes its neighbor's entry on rotate, or on
// shift at or above sel, and is written, or has only its enable written, when selected; depends on mpt_pkg
`timescale 1ns / 1ps

module mpt_cell #(
   parameter int INDEX = 0
) (
   input  logic                 clock,
   input  mpt_pkg::cell_ctl_type ctl,
   input  mpt_pkg::entry_type   next_entry,
   output mpt_pkg::entry_type   entry
);

   localparam logic [7:0] MY_INDEX = 8'(INDEX);

   mpt_pkg::entry_type entry_ff;
   mpt_pkg::entry_type entry_in;

   always_comb begin
      entry_in = entry_ff;
      unique case (ctl.cmd)
         mpt_pkg::CMD_ROTATE: begin
            entry_in = next_entry;
         end
         mpt_pkg::CMD_SHIFT: begin
            if (MY_INDEX >= ctl.sel) begin
               entry_in = next_entry;
            end
         end
         mpt_pkg::CMD_WRITE: begin
            if (MY_INDEX == ctl.sel) begin
               entry_in = ctl.wr_entry;
            end
         end
         mpt_pkg::CMD_SET_EN: begin
            if (MY_INDEX == ctl.sel) begin
               entry_in.en = ctl.wr_entry.en;
            end
         end
         default: begin
            entry_in = entry_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign entry = entry_ff;

endmodule

FILE: src/memory_patch_table.sv
// memory patch table top: ring of mpt_cell entries, scan sequencer, rsp register
// append, delete, set enable, clear and bad requests: beat in the rsp register at the accept edge
// read and apply: a scan state rotates the ring through every cell, one cell a cycle unless an apply
// hit waits for the rsp register, then a flush state registers the last beat once rsp_ready allows
// one request at a time: a non-scan request each cycle while the rsp register is free, none in a scan
// synchronous reset clears the count and control, not entries; depends on mpt_pkg and mpt_cell
`timescale 1ns / 1ps

module memory_patch_table #(
   parameter int CAPACITY = mpt_pkg::CAPACITY_DEFAULT
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  mpt_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output mpt_pkg::rsp_type rsp_data
);

   localparam int CW = $clog2(CAPACITY + 1);
   localparam int SW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam logic [CW-1:0] CAP_COUNT = CW'(CAPACITY);
   localparam logic [SW-1:0] LAST_STEP = SW'(CAPACITY - 1);

   localparam logic [1:0] S_IDLE  = 2'd0;
   localparam logic [1:0] S_SCAN  = 2'd1;
   localparam logic [1:0] S_FLUSH = 2'd2;

   logic [1:0]         state_ff, state_in;
   logic [CW-1:0]      count_ff, count_in;
   logic [SW-1:0]      step_ff, step_in;
   logic [SW-1:0]      idx_ff, idx_in;
   logic [2:0]         op_ff, op_in;
   mpt_pkg::entry_type hold_ff, hold_in;
   logic               hold_valid_ff, hold_valid_in;
   mpt_pkg::rsp_type   rsp_ff, rsp_in;
   logic               rsp_valid_ff, rsp_valid_in;

   mpt_pkg::cell_ctl_type ctl;
   mpt_pkg::entry_type    cells [CAPACITY];

   genvar gi;
   generate
      for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
         mpt_cell #(
            .INDEX(gi)
         ) u_cell (
            .clock      (clock),
            .ctl        (ctl),
            .next_entry (cells[(gi + 1) % CAPACITY]),
            .entry      (cells[gi])
         );
      end
   endgenerate

   logic out_free;
   logic accept;
   logic valid_idx;
   logic in_range;
   logic hit;
   mpt_pkg::entry_type head;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == S_IDLE) && out_free;
   assign accept    = req_valid && req_ready;
   assign valid_idx = 9'(req_data.entry_index) < 9'(count_ff);
   assign head      = cells[0];
   assign in_range  = (CW + 1)'(step_ff) < (CW + 1)'(count_ff);
   assign hit       = in_range && head.en;

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      step_in       = step_ff;
      idx_in        = idx_ff;
      op_in         = op_ff;
      hold_in       = hold_ff;
      hold_valid_in = hold_valid_ff;
      rsp_in        = rsp_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      ctl.cmd       = mpt_pkg::CMD_HOLD;
      ctl.sel       = req_data.entry_index;
      ctl.wr_entry.addr  = req_data.patch_addr;
      ctl.wr_entry.value = req_data.patch_value;
      ctl.wr_entry.en    = req_data.enable_in;

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               op_in         = req_data.opcode;
               idx_in        = req_data.entry_index[SW-1:0];
               step_in       = '0;
               hold_valid_in = 1'b0;
               rsp_in        = '0;
               rsp_in.last   = 1'b1;
               rsp_valid_in  = 1'b1;
               unique case (req_data.opcode)
                  mpt_pkg::OP_APPEND: begin
                     if (count_ff < CAP_COUNT) begin
                        ctl.cmd     = mpt_pkg::CMD_WRITE;
                        ctl.sel     = 8'(count_ff);
                        rsp_in.ok   = 1'b1;
                        rsp_in.slot = 6'(count_ff);
                        count_in    = count_ff + 1'b1;
                     end
                  end
                  mpt_pkg::OP_DELETE: begin
                     if (valid_idx) begin
                        ctl.cmd   = mpt_pkg::CMD_SHIFT;
                        rsp_in.ok = 1'b1;
                        count_in  = count_ff - 1'b1;
                     end
                  end
                  mpt_pkg::OP_READ: begin
                     if (valid_idx) begin
                        rsp_valid_in = 1'b0;
                        state_in     = S_SCAN;
                     end
                  end
                  mpt_pkg::OP_SET_EN: begin
                     if (valid_idx) begin
                        ctl.cmd   = mpt_pkg::CMD_SET_EN;
                        rsp_in.ok = 1'b1;
                     end
                  end
                  mpt_pkg::OP_APPLY: begin
                     rsp_valid_in = 1'b0;
                     state_in     = S_SCAN;
                  end
                  mpt_pkg::OP_CLEAR: begin
                     rsp_in.ok = 1'b1;
                     count_in  = '0;
                  end
                  default: begin
                     rsp_in.ok = 1'b0;
                  end
               endcase
            end
         end
         S_SCAN: begin
            if (op_ff == mpt_pkg::OP_READ) begin
               ctl.cmd = mpt_pkg::CMD_ROTATE;
               if (step_ff == idx_ff) begin
                  hold_in       = head;
                  hold_valid_in = 1'b1;
               end
            end else if (!(hit && hold_valid_ff && !out_free)) begin
               ctl.cmd = mpt_pkg::CMD_ROTATE;
               if (hit) begin
                  if (hold_valid_ff) begin
                     rsp_in              = '0;
                     rsp_in.ok           = 1'b1;
                     rsp_in.addr_out     = hold_ff.addr;
                     rsp_in.value_out    = hold_ff.value;
                     rsp_in.write_strobe = 1'b1;
                     rsp_valid_in        = 1'b1;
                  end
                  hold_in       = head;
                  hold_valid_in = 1'b1;
               end
            end
            if (ctl.cmd == mpt_pkg::CMD_ROTATE) begin
               step_in = step_ff + 1'b1;
               if (step_ff == LAST_STEP) begin
                  state_in = S_FLUSH;
               end
            end
         end
         S_FLUSH: begin
            if (out_free) begin
               rsp_in       = '0;
               rsp_in.ok    = 1'b1;
               rsp_in.last  = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
               if (hold_valid_ff) begin
                  rsp_in.addr_out  = hold_ff.addr;
                  rsp_in.value_out = hold_ff.value;
                  if (op_ff == mpt_pkg::OP_READ) begin
                     rsp_in.enable_out = hold_ff.en;
                  end else begin
                     rsp_in.write_strobe = 1'b1;
                  end
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         count_ff      <= '0;
         step_ff       <= '0;
         op_ff         <= mpt_pkg::OP_CLEAR;
         hold_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         step_ff       <= step_in;
         op_ff         <= op_in;
         hold_valid_ff <= hold_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff  <= idx_in;
      hold_ff <= hold_in;
      rsp_ff  <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CAP_COUNT)
      else $error("entry count beyond capacity");

   a_ready_idle: assert property (@(posedge clock) disable iff (reset)
      req_ready |-> state_ff == S_IDLE && out_free)
      else $error("request taken outside idle");

   a_strobe_apply: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.write_strobe |-> op_ff == mpt_pkg::OP_APPLY)
      else $error("write beat outside apply");

   a_scan_entry: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_IDLE && state_in == S_SCAN |-> accept && !rsp_valid_in)
      else $error("scan started without a request");

endmodule

FILE: tb/tb_memory_patch_table.sv
// testbench for memory_patch_table: directed table then biased random requests,
// every rsp beat checked against a directed expectation or an in-bench patch table predictor
// depends on mpt_pkg and memory_patch_table
`timescale 1ns / 1ps

module tb_memory_patch_table;

   localparam int CAPACITY     = mpt_pkg::CAPACITY_DEFAULT;
   localparam int CLK_PERIOD   = 8;
   localparam int RESET_CYCLES = 12;
   localparam int RANDOM_ITEMS = 410;
   localparam int CYCLE_LIMIT  = 2_000_000;
   localparam int SHOW_LIMIT   = 10;

   localparam logic [2:0] OP_UNDEF_6 = 3'd6;
   localparam logic [2:0] OP_UNDEF_7 = 3'd7;

   typedef struct {
      mpt_pkg::req_type beat;
      int               reps;
      bit               typed;
      mpt_pkg::rsp_type want;
   } dir_row_type;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_ready;
   mpt_pkg::req_type req_data = '0;
   logic             rsp_valid;
   logic             rsp_ready = 1'b0;
   mpt_pkg::rsp_type rsp_data;

   // predictor state
   logic [15:0] tbl_addr [CAPACITY];
   logic [7:0]  tbl_value [CAPACITY];
   logic        tbl_en [CAPACITY];
   int          patch_count = 0;

   mpt_pkg::rsp_type step_rsp [$];
   mpt_pkg::rsp_type pending_rsp [$];
   bit               typed_flag = 1'b0;
   mpt_pkg::rsp_type typed_want = '0;
   int               errors = 0;
   int               cycles = 0;
   int               burst_left = 0;
   int               stall_mode = 0;
   int               stall_left = 0;

   memory_patch_table #(
      .CAPACITY(CAPACITY)
   ) u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_data (req_data),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data (rsp_data)
   );

   always #(CLK_PERIOD / 2) clock = ~clock;

   function automatic mpt_pkg::req_type mk_req(logic [2:0] op, logic [7:0] idx,
                                               logic [15:0] addr, logic [7:0] value,
                                               logic en);
      mpt_pkg::req_type b;
      b.opcode      = op;
      b.entry_index = idx;
      b.patch_addr  = addr;
      b.patch_value = value;
      b.enable_in   = en;
      return b;
   endfunction

   function automatic mpt_pkg::rsp_type mk_rsp(logic ok, logic [5:0] slot, logic [15:0] addr,
                                               logic [7:0] value, logic en, logic wr,
                                               logic last);
      mpt_pkg::rsp_type r;
      r.ok           = ok;
      r.slot         = slot;
      r.addr_out     = addr;
      r.value_out    = value;
      r.enable_out   = en;
      r.write_strobe = wr;
      r.last         = last;
      return r;
   endfunction

   // updates the patch table and leaves the beats this request yields in step_rsp
   task automatic compute_patch_rsp(input mpt_pkg::req_type b);
      mpt_pkg::rsp_type r;
      int               i;
      logic             idx_ok;
      step_rsp.delete();
      r      = '0;
      r.last = 1'b1;
      idx_ok = b.entry_index < patch_count;
      case (b.opcode)
         mpt_pkg::OP_APPEND: begin
            if (patch_count < CAPACITY) begin
               tbl_addr[patch_count]  = b.patch_addr;
               tbl_value[patch_count] = b.patch_value;
               tbl_en[patch_count]    = b.enable_in;
               r.ok   = 1'b1;
               r.slot = 6'(patch_count);
               patch_count++;
            end
            step_rsp.push_back(r);
         end
         mpt_pkg::OP_DELETE: begin
            if (idx_ok) begin
               for (i = b.entry_index; i + 1 < patch_count; i++) begin
                  tbl_addr[i]  = tbl_addr[i + 1];
                  tbl_value[i] = tbl_value[i + 1];
                  tbl_en[i]    = tbl_en[i + 1];
               end
               patch_count--;
               r.ok = 1'b1;
            end
            step_rsp.push_back(r);
         end
         mpt_pkg::OP_READ: begin
            if (idx_ok) begin
               r.ok         = 1'b1;
               r.addr_out   = tbl_addr[b.entry_index];
               r.value_out  = tbl_value[b.entry_index];
               r.enable_out = tbl_en[b.entry_index];
            end
            step_rsp.push_back(r);
         end
         mpt_pkg::OP_SET_EN: begin
            if (idx_ok) begin
               tbl_en[b.entry_index] = b.enable_in;
               r.ok = 1'b1;
            end
            step_rsp.push_back(r);
         end
         mpt_pkg::OP_APPLY: begin
            for (i = 0; i < patch_count; i++) begin
               if (tbl_en[i]) begin
                  step_rsp.push_back(mk_rsp(1'b1, '0, tbl_addr[i], tbl_value[i],
                                            1'b0, 1'b1, 1'b0));
               end
            end
            if (step_rsp.size() == 0) begin
               r.ok = 1'b1;
               step_rsp.push_back(r);
            end else begin
               r      = step_rsp.pop_back();
               r.last = 1'b1;
               step_rsp.push_back(r);
            end
         end
         mpt_pkg::OP_CLEAR: begin
            patch_count = 0;
            r.ok = 1'b1;
            step_rsp.push_back(r);
         end
         default: begin
            step_rsp.push_back(r);
         end
      endcase
   endtask

   task automatic note_mismatch(input string what, input mpt_pkg::rsp_type want,
                                input mpt_pkg::rsp_type got);
      errors++;
      if (errors <= SHOW_LIMIT) begin
         $display("mismatch%0s: exp ok=%0d slot=%0d addr=%h val=%h en=%0d wr=%0d last=%0d",
                  what, want.ok, want.slot, want.addr_out, want.value_out, want.enable_out,
                  want.write_strobe, want.last);
         $display("          got ok=%0d slot=%0d addr=%h val=%h en=%0d wr=%0d last=%0d",
                  got.ok, got.slot, got.addr_out, got.value_out, got.enable_out,
                  got.write_strobe, got.last);
      end
   endtask

   // scoreboard: expectations pushed on request accept, rsp beats popped in order
   always @(posedge clock) begin
      mpt_pkg::rsp_type want;
      string            bad;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            if (pending_rsp.size() == 0) begin
               note_mismatch(" (no beat expected)", '0, rsp_data);
            end else begin
               want = pending_rsp.pop_front();
               bad  = "";
               if (rsp_data.ok !== want.ok) bad = {bad, " ok"};
               if (rsp_data.slot !== want.slot) bad = {bad, " slot"};
               if (rsp_data.addr_out !== want.addr_out) bad = {bad, " addr_out"};
               if (rsp_data.value_out !== want.value_out) bad = {bad, " value_out"};
               if (rsp_data.enable_out !== want.enable_out) bad = {bad, " enable_out"};
               if (rsp_data.write_strobe !== want.write_strobe) bad = {bad, " write_strobe"};
               if (rsp_data.last !== want.last) bad = {bad, " last"};
               if (bad != "") note_mismatch({" in", bad}, want, rsp_data);
            end
         end
         if (req_valid && req_ready) begin
            compute_patch_rsp(req_data);
            if (typed_flag) begin
               pending_rsp.push_back(typed_want);
            end else begin
               foreach (step_rsp[i]) pending_rsp.push_back(step_rsp[i]);
            end
         end
      end
   end

   // receiver: modes of always ready, mostly ready and mostly stalled
   always @(negedge clock) begin
      if (stall_left == 0) begin
         stall_mode <= $urandom_range(0, 2);
         stall_left <= $urandom_range(16, 160);
      end else begin
         stall_left <= stall_left - 1;
      end
      case (stall_mode)
         0: rsp_ready <= 1'b1;
         1: rsp_ready <= $urandom_range(0, 3) != 0;
         default: rsp_ready <= $urandom_range(0, 3) == 0;
      endcase
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("status: fail");
         $finish;
      end
   end

   // called at a falling edge, returns at the falling edge after the beat is taken
   task automatic send_item(input mpt_pkg::req_type b, input bit typed,
                            input mpt_pkg::rsp_type want);
      int gap_len;
      if (burst_left == 0) begin
         gap_len    = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
         burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60)
                                                  : $urandom_range(1, 8);
         if (gap_len > 0) begin
            req_valid <= 1'b0;
            repeat (gap_len) @(negedge clock);
         end
      end
      typed_flag = typed;
      typed_want = want;
      req_valid <= 1'b1;
      req_data  <= b;
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
      burst_left--;
   endtask

   initial begin
      dir_row_type      dir_rows [$];
      mpt_pkg::rsp_type refused;
      mpt_pkg::rsp_type done_ok;
      mpt_pkg::req_type beat;
      int               rep;
      int               n;
      int               fill_mode;
      int               roll;
      int               lim_app, lim_rd, lim_set, lim_apl, lim_del, lim_clr;

      refused = mk_rsp(1'b0, '0, '0, '0, 1'b0, 1'b0, 1'b1);
      done_ok = mk_rsp(1'b1, '0, '0, '0, 1'b0, 1'b0, 1'b1);

      // empty table, bad opcodes, first appends, then reads, applies, enable, delete and clear
      dir_rows.push_back('{mk_req(mpt_pkg::OP_READ, 0, 0, 0, 0), 1, 1'b1, refused});
      dir_rows.push_back('{mk_req(mpt_pkg::OP_DELETE, 0, 0, 0, 0), 1, 1'b1, refused});
      dir_rows.push_back('{mk_req(mpt_pkg::OP_SET_EN, 255, 0, 0, 1), 1, 1'b1, refused});
      dir_rows.push_back('{mk_req(mpt_pkg::OP_APPLY, 0, 0, 0, 0), 1, 1'b1, done_ok});
      dir_rows.push_back('{mk_req(OP_UNDEF_6, 0, 0, 0, 0), 1, 1'b1, refused});
      dir_rows.push_back('{mk_req(OP_UNDEF_7, 255, 16'hffff, 8'hff, 1), 1, 1'b1, refused});
      dir_rows.push_back('{mk_req(mpt_pkg::OP_APPEND, 0, 16'h0000, 8'h00, 1), 1, 1'b1,
                           mk_rsp(1'b1, 6'd0, '0, '0, 1'b0, 1'b0, 1'b1)});
      dir_rows.push_back('{mk_req(mpt_pkg::OP_APPEND, 255, 16'hffff, 8'hff, 0), 1, 1'b1,
                           mk_rsp(1'b1, 6'd1, '0, '0, 1'b0, 1'b0, 1'b1)});
      dir_rows.push_back('{mk_req(mpt_pkg::OP_APPEND, 0, 16'h1234, 8'h5a, 1), 1, 1'b1,
                           mk_rsp(1'b1, 6'd2, '0, '0, 1'b0, 1'b0, 1'b1)});
      dir_rows.push_back('{mk_req(mpt_pkg::OP_READ, 1, 0, 0, 0), 1, 1'b1,
                           mk_rsp(1'b1, '0, 16'hffff, 8'hff, 1'b0, 1'b0, 1'b1)});
      dir_rows.push_back('{mk_req(mpt_pkg::OP_READ, 3, 0, 0, 0), 1, 1'b1, refused});
      dir_rows.push_back('{mk_req(mpt_pkg::OP_APPLY, 0, 0, 0, 0), 1, 1'b0, '0});
      dir_rows.push_back('{mk_req(mpt_pkg::OP_SET_EN, 1, 0, 0, 1), 1, 1'b1, done_ok});
      dir_rows.push_back('{mk_req(mpt_pkg::OP_APPLY, 0, 0, 0, 0), 1, 1'b0, '0});
      dir_rows.push_back('{mk_req(mpt_pkg::OP_DELETE, 0, 0, 0, 0), 1, 1'b1, done_ok});
      dir_rows.push_back('{mk_req(mpt_pkg::OP_READ, 0, 0, 0, 0), 1, 1'b0, '0});
      dir_rows.push_back('{mk_req(mpt_pkg::OP_CLEAR, 0, 0, 0, 0), 1, 1'b1, done_ok});
      dir_rows.push_back('{mk_req(mpt_pkg::OP_READ, 0, 0, 0, 0), 1, 1'b1, refused});
      // fill to capacity, overflow, full apply, edge deletes, enable, read, apply and clear
      dir_rows.push_back('{mk_req(mpt_pkg::OP_APPEND, 0, 16'hc000, 8'h80, 1), CAPACITY, 1'b0,
                           '0});
      dir_rows.push_back('{mk_req(mpt_pkg::OP_APPEND, 0, 16'hbeef, 8'h11, 1), 1, 1'b1, refused});
      dir_rows.push_back('{mk_req(mpt_pkg::OP_APPLY, 0, 0, 0, 0), 1, 1'b0, '0});
      dir_rows.push_back('{mk_req(mpt_pkg::OP_DELETE, 8'(CAPACITY - 1), 0, 0, 0), 1, 1'b1,
                           done_ok});
      dir_rows.push_back('{mk_req(mpt_pkg::OP_DELETE, 0, 0, 0, 0), 1, 1'b1, done_ok});
      dir_rows.push_back('{mk_req(mpt_pkg::OP_SET_EN, 8'(CAPACITY - 3), 0, 0, 0), 1, 1'b1,
                           done_ok});
      dir_rows.push_back('{mk_req(mpt_pkg::OP_READ, 8'(CAPACITY - 3), 0, 0, 0), 1, 1'b0, '0});
      dir_rows.push_back('{mk_req(mpt_pkg::OP_APPLY, 0, 0, 0, 0), 1, 1'b0, '0});
      dir_rows.push_back('{mk_req(mpt_pkg::OP_CLEAR, 0, 0, 0, 0), 1, 1'b1, done_ok});

      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (dir_rows[k]) begin
         for (rep = 0; rep < dir_rows[k].reps; rep++) begin
            beat             = dir_rows[k].beat;
            beat.patch_addr  = beat.patch_addr ^ 16'(rep);
            beat.patch_value = beat.patch_value + 8'(rep);
            send_item(beat, dir_rows[k].typed, dir_rows[k].want);
         end
      end

      for (n = 0; n < RANDOM_ITEMS; n++) begin
         if (n % 40 == 0) fill_mode = $urandom_range(0, 9);
         if (fill_mode < 5) begin
            lim_app = 62; lim_rd = 74; lim_set = 84; lim_apl = 91; lim_del = 98; lim_clr = 98;
         end else if (fill_mode < 8) begin
            lim_app = 30; lim_rd = 45; lim_set = 60; lim_apl = 72; lim_del = 95; lim_clr = 97;
         end else begin
            lim_app = 15; lim_rd = 30; lim_set = 40; lim_apl = 52; lim_del = 95; lim_clr = 96;
         end
         beat.entry_index = 8'($urandom_range(0, 255));
         beat.patch_addr  = 16'($urandom_range(0, 65535));
         beat.patch_value = 8'($urandom_range(0, 255));
         beat.enable_in   = 1'($urandom_range(0, 1));
         roll = $urandom_range(0, 99);
         if (roll < lim_app) beat.opcode = mpt_pkg::OP_APPEND;
         else if (roll < lim_rd) beat.opcode = mpt_pkg::OP_READ;
         else if (roll < lim_set) beat.opcode = mpt_pkg::OP_SET_EN;
         else if (roll < lim_apl) beat.opcode = mpt_pkg::OP_APPLY;
         else if (roll < lim_del) beat.opcode = mpt_pkg::OP_DELETE;
         else if (roll < lim_clr) beat.opcode = mpt_pkg::OP_CLEAR;
         else beat.opcode = ($urandom_range(0, 1) == 0) ? OP_UNDEF_6 : OP_UNDEF_7;
         // mostly valid indexes so deletes and reads hit live entries
         if (patch_count > 0 && $urandom_range(0, 99) < 85) begin
            beat.entry_index = 8'($urandom_range(0, patch_count - 1));
         end
         send_item(beat, 1'b0, '0);
      end
      req_valid <= 1'b0;

      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (2 * CAPACITY + 20) @(posedge clock);
      if (errors == 0 && pending_rsp.size() == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
